### rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Check a property on every clock edge, reset included.
`define ASSERT_ANY(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

### rtl/rmq_pkg.sv
// Shared types and constants for the range maximum block.
package rmq_pkg;

  localparam int IDX_W = 11;
  localparam int VAL_W = 16;
  localparam int OUT_W = 16;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic upd_wr;
    logic capture;
    logic scan_rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_end;
    logic upd_ok;
    logic range_empty;
    logic scan_end;
    logic out_busy;
  } stat_t;

endpackage

### rtl/rmq_ctrl.sv
// Controller state machine: clearing pass, update, query scan and result hand-off.
module rmq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           operation,
  input  rmq_pkg::stat_t stat,
  output logic           in_ready,
  output rmq_pkg::cmd_t  cmd
);
  import rmq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (stat.clr_end) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid && operation == OP_QUERY) begin
          state_next = stat.range_empty ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.scan_end) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!stat.out_busy) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
      end
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.upd_wr  = in_valid && operation == OP_UPDATE && stat.upd_ok;
        cmd.capture = in_valid && operation == OP_QUERY;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
      end
      ST_DONE: begin
        cmd.out_load = !stat.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### rtl/rmq_dp.sv
// Datapath: score memory, range bounds, scan address, running maximum and output register.
module rmq_dp #(
  parameter int TABLE_DEPTH = 1024,
  parameter int SCORE_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr,
  input  logic [rmq_pkg::IDX_W-1:0] entries_in_use,
  input  logic [rmq_pkg::IDX_W-1:0] first_index,
  input  logic [rmq_pkg::VAL_W-1:0] second_value,
  input  rmq_pkg::cmd_t             cmd,
  input  logic                      out_ready,
  output rmq_pkg::stat_t            stat,
  output logic                      out_valid,
  output logic [rmq_pkg::OUT_W-1:0] max_score
);
  import rmq_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W  = (CNT_W > VAL_W) ? CNT_W : VAL_W;
  localparam int EXT_W  = (SCORE_WIDTH > OUT_W) ? SCORE_WIDTH : OUT_W;

  logic [SCORE_WIDTH-1:0] mem [TABLE_DEPTH];

  logic [IDX_W-1:0]       used_limit;
  logic [ADDR_W-1:0]      addr;
  logic [ADDR_W-1:0]      last_addr;
  logic [SCORE_WIDTH-1:0] rd_data;
  logic                   rd_valid;
  logic [SCORE_WIDTH-1:0] best;

  logic [CMP_W-1:0]       first_c;
  logic [CMP_W-1:0]       second_c;
  logic [CMP_W-1:0]       limit_c;
  logic [CMP_W-1:0]       depth_c;
  logic [CMP_W-1:0]       used_c;
  logic [CMP_W-1:0]       last_c;
  logic                   first_zero;
  logic [ADDR_W-1:0]      first_addr;
  logic [EXT_W-1:0]       wdata_ext;
  logic [EXT_W-1:0]       best_ext;

  // Clip the count in use to the depth, then the query end to the count.
  always_comb begin
    first_c    = CMP_W'(first_index);
    second_c   = CMP_W'(second_value);
    limit_c    = CMP_W'(used_limit);
    depth_c    = CMP_W'(TABLE_DEPTH);
    used_c     = (limit_c > depth_c) ? depth_c : limit_c;
    last_c     = (second_c < used_c) ? second_c : used_c;
    first_zero = (first_index == '0);
    first_addr = ADDR_W'(first_c - CMP_W'(1));
    wdata_ext  = EXT_W'(second_value);
    best_ext   = EXT_W'(best);
  end

  always_comb begin
    stat.clr_end     = (addr == ADDR_W'(TABLE_DEPTH - 1));
    stat.upd_ok      = !first_zero && (first_c <= used_c);
    stat.range_empty = first_zero || (first_c > last_c);
    stat.scan_end    = (addr == last_addr);
    stat.out_busy    = out_valid;
  end

  // Single port: clear and update write, scan reads.
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[addr] <= '0;
    end else if (cmd.upd_wr) begin
      mem[first_addr] <= wdata_ext[SCORE_WIDTH-1:0];
    end
    if (cmd.scan_rd) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_limit <= '0;
      addr       <= '0;
      rd_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr) used_limit <= entries_in_use;
      if (cmd.capture) begin
        addr <= first_addr;
      end else if (cmd.clr_wr || cmd.scan_rd) begin
        addr <= addr + ADDR_W'(1);
      end
      rd_valid <= cmd.scan_rd;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      last_addr <= ADDR_W'(last_c - CMP_W'(1));
      best      <= '0;
    end else if (rd_valid && rd_data > best) begin
      best <= rd_data;
    end
    if (cmd.out_load) max_score <= best_ext[OUT_W-1:0];
  end

endmodule

### rtl/range_max_with_point_update.sv
// Top level of the range maximum block with point update.
// Keeps TABLE_DEPTH scores of SCORE_WIDTH bits in a single-port memory, entries numbered
// from 1, with the count in use written through the cfg channel (clipped to TABLE_DEPTH).
// After reset a clearing pass zeroes the memory, one entry a cycle; in_ready stays low
// until it ends. An update gives no result; updates at index zero or beyond the count
// are dropped. A query reads one entry per cycle through the memory port; an empty range
// skips the scan, and the result waits for the output register to drain. One item is in
// flight at a time; a finished result waits in the output register while the next item
// is taken.
module range_max_with_point_update #(
  parameter int TABLE_DEPTH = 1024,
  parameter int SCORE_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [rmq_pkg::IDX_W-1:0] entries_in_use,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      operation,
  input  logic [rmq_pkg::IDX_W-1:0] first_index,
  input  logic [rmq_pkg::VAL_W-1:0] second_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [rmq_pkg::OUT_W-1:0] max_score
);
  import rmq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  rmq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .stat      (stat),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  rmq_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .SCORE_WIDTH (SCORE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr         (cfg_valid && cfg_ready),
    .entries_in_use (entries_in_use),
    .first_index    (first_index),
    .second_value   (second_value),
    .cmd            (cmd),
    .out_ready      (out_ready),
    .stat           (stat),
    .out_valid      (out_valid),
    .max_score      (max_score)
  );

endmodule

### rtl/rmq_checker.sv
// Port-level checks for the range maximum block, bound to the top level.
`include "assert_macros.svh"

module rmq_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      operation,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [rmq_pkg::OUT_W-1:0] max_score
);
  import rmq_pkg::*;

  // Reset starts the clearing pass with no result pending.
  `ASSERT_ANY(a_reset_busy, rst |=> !in_ready && !out_valid)

  // A query transaction occupies the block for at least the next cycle.
  `ASSERT_CLK(a_query_busy, in_valid && in_ready && operation == OP_QUERY |=> !in_ready)

  // An update transaction leaves the block ready again in the next cycle.
  `ASSERT_CLK(a_update_quick, in_valid && in_ready && operation == OP_UPDATE |=> in_ready)

  // A result only appears at the end of a query, never from the idle state.
  `ASSERT_CLK(a_result_source, $rose(out_valid) |-> !$past(in_ready))

  // Hold the result while stalled.
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(max_score))

endmodule

bind range_max_with_point_update rmq_checker u_rmq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .operation (operation),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .max_score (max_score)
);
